/* design/pending_request_queue_macros.svh */
// Assertion helpers for the pending request queue.
`ifndef PENDING_REQUEST_QUEUE_MACROS_SVH
`define PENDING_REQUEST_QUEUE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset
`define PRQ_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pending_request_queue: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset
`define PRQ_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pending_request_queue: next-cycle check failed");
`else
`define PRQ_ASSERT_IMP(name, pre, post)
`define PRQ_ASSERT_NXT(name, pre, post)
`endif
`endif

/* design/prq_pkg.sv */
package prq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CONNECTIONS_DEF = 5;

  localparam logic [31:0] EXPIRY_RST = 32'd5000;
  localparam logic [31:0] IDLE_RST   = 32'd5000;

  // Register indexes
  localparam logic REG_EXPIRY = 1'b0;
  localparam logic REG_IDLE   = 1'b1;

  // Command kinds
  localparam logic [2:0] K_ENQUEUE = 3'd0;
  localparam logic [2:0] K_CLEANUP = 3'd1;
  localparam logic [2:0] K_DISPATCH = 3'd2;
  localparam logic [2:0] K_CONNECT = 3'd3;
  localparam logic [2:0] K_CLOSE   = 3'd4;
  localparam logic [2:0] K_IDLECHK = 3'd5;

  // Result status codes
  localparam logic [3:0] ST_QUEUED  = 4'd0;
  localparam logic [3:0] ST_DUP     = 4'd1;
  localparam logic [3:0] ST_FULL    = 4'd2;
  localparam logic [3:0] ST_CLEANED = 4'd3;
  localparam logic [3:0] ST_SKIPPED = 4'd4;
  localparam logic [3:0] ST_ICON    = 4'd5;
  localparam logic [3:0] ST_PAGE    = 4'd6;
  localparam logic [3:0] ST_IDLE    = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  typedef struct packed {
    logic [2:0]  conn;
    logic        fav;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_WAIT,
    S_EXEC,
    S_CLEAN,
    S_DISP,
    S_SCAN,
    S_IDLEOUT
  } state_t;

endpackage

/* design/prq_cell.sv */
module prq_cell
  import prq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nb,
  input  entry_t     wr_data,
  input  logic [2:0] probe,
  output entry_t     q,
  output logic       hit
);

  entry_t q_r;

  // Load a new entry, else take the right neighbor's entry, else hold
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r <= wr_data;
    end else if (ctrl.shift) begin
      q_r <= nb;
    end
  end

  assign q   = q_r;
  assign hit = (q_r.conn == probe);

endmodule

/* design/pending_request_queue.sv */
// Pending request queue: a row of QUEUE_DEPTH entry cells that shift toward
// the head, beside a table of CONNECTIONS closed flags and activity stamps.
// One command is taken at a time; the next is accepted when it is done:
// - Enqueue, connect, close and unused kinds give a single result.
// - Cleanup rotates the queue once through the head cell, one entry a
//   cycle, and then gives a single result.
// - Dispatch pops the queue, one result a cycle while the result output
//   is not stalled, and gives a single result on an empty queue.
// - Idle check checks the table one entry a cycle and then walks it up to
//   the highest connection it closes, one entry a cycle while the result
//   output is not stalled.
// A stalled result output holds up any command that has a result to give.
// Registers: 0x0 request_expiry, 0x4 idle_limit, both reset to 5000.
`include "pending_request_queue_macros.svh"
module pending_request_queue
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CONNECTIONS = CONNECTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // conn[2:0], now[34:3], zero pad
  input  logic [3:0]  in_tuser,   // kind[2:0], favicon[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // conn_out[2:0], count[6:3], zero pad
  output logic [4:0]  out_tuser,  // status[3:0], favicon_out[4]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CIW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  // Configuration
  logic [31:0] expiry_r, idle_lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r   <= EXPIRY_RST;
      idle_lim_r <= IDLE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_EXPIRY) begin
        expiry_r <= cfg_pwdata;
      end else begin
        idle_lim_r <= cfg_pwdata;
      end
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_IDLE) ? idle_lim_r : expiry_r;
  assign cfg_pready = 1'b1;

  // Command and control registers
  state_t           state_r, state_nxt;
  logic [2:0]       kind_r, conn_r;
  logic             fav_r;
  logic [31:0]      now_r;
  logic [CW-1:0]    cnt_r, cnt_nxt, step_r, step_nxt, rem_r, rem_nxt;
  logic [CIW-1:0]   idx_r, idx_nxt;
  logic [CONNECTIONS-1:0] mask_r, mask_nxt;

  // Connection table
  logic [CONNECTIONS-1:0] closed_r;
  logic [31:0]            act_r [CONNECTIONS];
  logic                   tbl_open, tbl_close;
  logic [CIW-1:0]         tbl_idx;

  // Output register
  logic       ov_r;
  logic [3:0] o_st_r, o_cnt_r;
  logic [2:0] o_conn_r;
  logic       o_fav_r, o_last_r;
  logic       emit, out_free;
  logic [3:0] e_st, e_cnt;
  logic [2:0] e_conn;
  logic       e_fav, e_last;

  // Cell row
  entry_t               q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit, hit_v;
  cell_ctrl_t           ctrl [QUEUE_DEPTH];
  logic                 shift_all, wr_en;
  logic [CW-1:0]        wr_pos;
  entry_t               wr_data;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t nb;
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = q[g+1];
    end
    assign ctrl[g].shift = shift_all;
    assign ctrl[g].load  = wr_en && (wr_pos == CW'(g));
    assign hit_v[g]      = hit[g] && (CW'(g) < cnt_r);
    prq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[g]),
      .nb      (nb),
      .wr_data (wr_data),
      .probe   (conn_r),
      .q       (q[g]),
      .hit     (hit[g])
    );
  end

  assign in_tready = (state_r == S_WAIT);
  assign out_free  = !ov_r || out_tready;

  logic conn_ok, head_ok, head_closed, head_old, scan_quiet;
  logic [CW-1:0] cnt_dec;
  logic [CONNECTIONS-1:0] mask_clr;

  always_comb begin
    conn_ok     = ({1'b0, conn_r} < 4'(CONNECTIONS));
    head_ok     = ({1'b0, q[0].conn} < 4'(CONNECTIONS));
    head_closed = head_ok ? closed_r[q[0].conn[CIW-1:0]] : 1'b1;
    head_old    = (now_r - q[0].stamp) > expiry_r;
    scan_quiet  = !closed_r[idx_r] && ((now_r - act_r[idx_r]) > idle_lim_r);
    cnt_dec     = cnt_r - CW'(1);
    mask_clr    = mask_r & ~(CONNECTIONS'(1) << idx_r);

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    mask_nxt  = mask_r;
    tbl_open  = 1'b0;
    tbl_close = 1'b0;
    tbl_idx   = conn_r[CIW-1:0];
    shift_all = 1'b0;
    wr_en     = 1'b0;
    wr_pos    = cnt_r;
    wr_data   = '{conn: conn_r, fav: fav_r, stamp: now_r};
    emit      = 1'b0;
    e_st      = ST_DONE;
    e_conn    = conn_r;
    e_fav     = 1'b0;
    e_cnt     = 4'(cnt_r);
    e_last    = 1'b1;

    case (state_r)
      S_WAIT: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (kind_r)
          K_CLEANUP: begin
            step_nxt  = cnt_r;
            rem_nxt   = '0;
            state_nxt = S_CLEAN;
          end
          K_DISPATCH: begin
            if (cnt_r != '0) begin
              state_nxt = S_DISP;
            end else if (out_free) begin
              emit      = 1'b1;
              e_conn    = 3'd0;
              state_nxt = S_WAIT;
            end
          end
          K_IDLECHK: begin
            idx_nxt   = '0;
            mask_nxt  = '0;
            state_nxt = S_SCAN;
          end
          default: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_WAIT;
              if (conn_ok && kind_r == K_ENQUEUE) begin
                tbl_open = 1'b1;
                e_fav    = 1'b0;
                if (hit_v != '0) begin
                  e_st = ST_DUP;
                end else if (cnt_r >= CW'(QUEUE_DEPTH)) begin
                  e_st = ST_FULL;
                end else begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + CW'(1);
                  e_st    = ST_QUEUED;
                  e_fav   = fav_r;
                  e_cnt   = 4'(cnt_r + CW'(1));
                end
              end else if (conn_ok && kind_r == K_CONNECT) begin
                tbl_open = 1'b1;
              end else if (conn_ok && kind_r == K_CLOSE) begin
                tbl_close = 1'b1;
              end
            end
          end
        endcase
      end
      S_CLEAN: begin
        // Rotate the head through the tail, dropping stale or closed entries
        if (step_r == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            e_st      = ST_CLEANED;
            e_conn    = 3'd0;
            e_cnt     = 4'(rem_r);
            state_nxt = S_WAIT;
          end
        end else begin
          shift_all = 1'b1;
          step_nxt  = step_r - CW'(1);
          wr_data   = q[0];
          wr_pos    = cnt_dec;
          if (head_closed || head_old) begin
            cnt_nxt = cnt_dec;
            rem_nxt = rem_r + CW'(1);
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      S_DISP: begin
        // Pop the head, one result a beat
        if (out_free) begin
          shift_all = 1'b1;
          cnt_nxt   = cnt_dec;
          emit      = 1'b1;
          e_conn    = q[0].conn;
          e_fav     = q[0].fav;
          e_cnt     = 4'(cnt_dec);
          e_last    = (cnt_dec == '0);
          if (head_closed) begin
            e_st = ST_SKIPPED;
          end else begin
            e_st      = q[0].fav ? ST_ICON : ST_PAGE;
            tbl_close = 1'b1;
            tbl_idx   = q[0].conn[CIW-1:0];
          end
          if (cnt_dec == '0) state_nxt = S_WAIT;
        end
      end
      S_SCAN: begin
        // Mark quiet open connections, one per cycle
        mask_nxt[idx_r] = scan_quiet;
        if (idx_r == CIW'(CONNECTIONS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLEOUT;
        end else begin
          idx_nxt = idx_r + CIW'(1);
        end
      end
      S_IDLEOUT: begin
        if (mask_r == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            e_conn    = 3'd0;
            state_nxt = S_WAIT;
          end
        end else if (mask_r[idx_r]) begin
          if (out_free) begin
            emit      = 1'b1;
            e_st      = ST_IDLE;
            e_conn    = 3'(idx_r);
            e_last    = (mask_clr == '0);
            tbl_close = 1'b1;
            tbl_idx   = idx_r;
            mask_nxt  = mask_clr;
            idx_nxt   = idx_r + CIW'(1);
            if (mask_clr == '0) state_nxt = S_WAIT;
          end
        end else begin
          idx_nxt = idx_r + CIW'(1);
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      cnt_r   <= '0;
      step_r  <= '0;
      rem_r   <= '0;
      idx_r   <= '0;
      mask_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // Latch the command beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser[2:0];
      fav_r  <= in_tuser[3];
      conn_r <= in_tdata[2:0];
      now_r  <= in_tdata[34:3];
    end
  end

  // Connection table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= '0;
      for (int i = 0; i < CONNECTIONS; i++) act_r[i] <= '0;
    end else if (tbl_open) begin
      closed_r[tbl_idx] <= 1'b0;
      act_r[tbl_idx]    <= now_r;
    end else if (tbl_close) begin
      closed_r[tbl_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      o_st_r   <= e_st;
      o_conn_r <= e_conn;
      o_fav_r  <= e_fav;
      o_cnt_r  <= e_cnt;
      o_last_r <= e_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, o_cnt_r, o_conn_r};
  assign out_tuser  = {o_fav_r, o_st_r};
  assign out_tlast  = o_last_r;

  `PRQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(QUEUE_DEPTH))
  `PRQ_ASSERT_NXT(a_one_cmd, in_tvalid && in_tready, !in_tready)
  `PRQ_ASSERT_IMP(a_clean_conn, ov_r && o_st_r == ST_CLEANED, o_conn_r == 3'd0)

endmodule

/* tb/prq_checker.sv */
module prq_checker
  import prq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // conn[2:0], now[34:3], zero pad
  input  logic [3:0]  in_tuser,   // kind[2:0], favicon[3]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // conn_out[2:0], count[6:3], zero pad
  input  logic [4:0]  out_tuser,  // status[3:0], favicon_out[4]
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int NCONN = CONNECTIONS_DEF;

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] conn;
    logic       fav;
    logic [3:0] count;
    logic       last;
  } reply_t;

  reply_t      replies_due[$];
  logic [31:0] expiry_ms;
  logic [31:0] idle_ms;
  entry_t      q_entry [DEPTH];
  int          q_len;
  logic        closed [NCONN];
  logic [31:0] activity [NCONN];

  assign pending = replies_due.size();

  function automatic reply_t mk(logic [3:0] st, logic [2:0] c, logic f,
                                logic [3:0] cnt, logic l);
    reply_t r;
    r.status = st; r.conn = c; r.fav = f; r.count = cnt; r.last = l;
    return r;
  endfunction

  function automatic void drop_at(int idx);
    for (int j = idx + 1; j < q_len; j++) q_entry[j-1] = q_entry[j];
    q_len--;
  endfunction

  function automatic logic is_closed(logic [2:0] c);
    return (c < NCONN) ? closed[c] : 1'b1;
  endfunction

  // Advance the queue model by one command and queue its replies
  function automatic void predict_command(logic [2:0] kind, logic [2:0] c, logic f,
                                          logic [31:0] now);
    logic    dup;
    int      idx;
    int      removed;
    int      n;
    entry_t  head;
    logic [3:0] st;
    dup = 1'b0; removed = 0; n = 0;
    if (kind == K_ENQUEUE && c < NCONN) begin
      closed[c] = 1'b0;
      activity[c] = now;
      for (int i = 0; i < q_len; i++) if (q_entry[i].conn == c) dup = 1'b1;
      if (dup) replies_due.push_back(mk(ST_DUP, c, 1'b0, 4'(q_len), 1'b1));
      else if (q_len >= DEPTH) replies_due.push_back(mk(ST_FULL, c, 1'b0, 4'(q_len), 1'b1));
      else begin
        q_entry[q_len] = '{conn: c, fav: f, stamp: now};
        q_len++;
        replies_due.push_back(mk(ST_QUEUED, c, f, 4'(q_len), 1'b1));
      end
    end else if (kind == K_CLEANUP) begin
      idx = 0;
      while (idx < q_len) begin
        if (is_closed(q_entry[idx].conn) || (now - q_entry[idx].stamp) > expiry_ms) begin
          drop_at(idx);
          removed++;
        end else idx++;
      end
      replies_due.push_back(mk(ST_CLEANED, 3'd0, 1'b0, 4'(removed), 1'b1));
    end else if (kind == K_DISPATCH) begin
      if (q_len == 0) replies_due.push_back(mk(ST_DONE, 3'd0, 1'b0, 4'd0, 1'b1));
      while (q_len > 0) begin
        head = q_entry[0];
        drop_at(0);
        if (is_closed(head.conn)) st = ST_SKIPPED;
        else begin
          st = head.fav ? ST_ICON : ST_PAGE;
          closed[head.conn] = 1'b1;
        end
        replies_due.push_back(mk(st, head.conn, head.fav, 4'(q_len), q_len == 0));
      end
    end else if (kind == K_CONNECT && c < NCONN) begin
      closed[c] = 1'b0;
      activity[c] = now;
      replies_due.push_back(mk(ST_DONE, c, 1'b0, 4'(q_len), 1'b1));
    end else if (kind == K_CLOSE && c < NCONN) begin
      closed[c] = 1'b1;
      replies_due.push_back(mk(ST_DONE, c, 1'b0, 4'(q_len), 1'b1));
    end else if (kind == K_IDLECHK) begin
      for (int i = 0; i < NCONN; i++) begin
        if (!closed[i] && (now - activity[i]) > idle_ms) begin
          closed[i] = 1'b1;
          replies_due.push_back(mk(ST_IDLE, 3'(i), 1'b0, 4'(q_len), 1'b0));
          n++;
        end
      end
      if (n > 0) replies_due[$].last = 1'b1;
      else replies_due.push_back(mk(ST_DONE, 3'd0, 1'b0, 4'(q_len), 1'b1));
    end else begin
      replies_due.push_back(mk(ST_DONE, c, 1'b0, 4'(q_len), 1'b1));
    end
  endfunction

  // Track register writes, predict on input beats, compare output beats
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      expiry_ms <= EXPIRY_RST;
      idle_ms <= IDLE_RST;
      q_len = 0;
      for (int i = 0; i < NCONN; i++) begin
        closed[i] = 1'b0;
        activity[i] = '0;
      end
      replies_due.delete();
      errors <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_IDLE) idle_ms <= cfg_pwdata;
        else expiry_ms <= cfg_pwdata;
      end
      if (out_tvalid && out_tready) begin
        got = mk(out_tuser[3:0], out_tdata[2:0], out_tuser[4], out_tdata[6:3], out_tlast);
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected st=%0d conn=%0d fav=%0d cnt=%0d last=%0d",
                     $time, want.status, want.conn, want.fav, want.count, want.last);
            $display("%0t:                 actual   st=%0d conn=%0d fav=%0d cnt=%0d last=%0d",
                     $time, got.status, got.conn, got.fav, got.count, got.last);
            errors <= errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_command(in_tuser[2:0], in_tdata[2:0], in_tuser[3], in_tdata[34:3]);
    end
  end
endmodule

/* tb/tb_pending_request_queue.sv */
module tb_pending_request_queue;
  import prq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // conn[2:0], now[34:3], zero pad
  logic [3:0]  in_tuser = '0;   // kind[2:0], favicon[3]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // conn_out[2:0], count[6:3], zero pad
  logic [4:0]  out_tuser;       // status[3:0], favicon_out[4]
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic [31:0] clock_ms = '0;
  bit          sink_active = 1'b0;

  always #2 clk = ~clk;

  pending_request_queue DUT (.*);

  prq_checker u_checker (.*);

  // Cap the run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Accept results with random stalls, sometimes none
  always @(posedge clk) begin
    int wait_n;
    if (sink_active) begin
      out_tready <= 1'b0;
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      repeat (wait_n) @(posedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Hold one command until the block takes it
  task automatic send_command(logic [2:0] kind, logic [2:0] c, logic f, logic [31:0] now,
                              bit gaps);
    if (gaps) repeat ($urandom_range(0, 19)) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= {f, kind};
    in_tdata <= {5'd0, now, c};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  // Time mostly creeps forward, sometimes jumps or wraps
  task automatic random_command(bit gaps);
    logic [2:0] kind;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = K_ENQUEUE;
    else if (pick < 52) kind = K_CLEANUP;
    else if (pick < 64) kind = K_DISPATCH;
    else if (pick < 74) kind = K_CONNECT;
    else if (pick < 84) kind = K_CLOSE;
    else if (pick < 95) kind = K_IDLECHK;
    else kind = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 3000);
    send_command(kind,
                 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4)),
                 1'($urandom_range(0, 1)), clock_ms, gaps);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_active = 1'b1;

    // Directed: enqueue five connections, a duplicate, out-of-range, every kind
    for (int c = 0; c < 5; c++) send_command(K_ENQUEUE, 3'(c), c[0], 32'(100 + c), 1'b0);
    send_command(K_ENQUEUE, 3'd2, 1'b1, 32'd200, 1'b1);
    send_command(K_ENQUEUE, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_command(K_CONNECT, 3'd5, 1'b0, 32'd0, 1'b0);
    send_command(K_CLOSE, 3'd6, 1'b0, 32'd0, 1'b0);
    send_command(3'd6, 3'd1, 1'b1, 32'd0, 1'b0);
    send_command(3'd7, 3'd4, 1'b0, 32'd0, 1'b0);
    send_command(K_CLOSE, 3'd1, 1'b0, 32'd300, 1'b0);
    send_command(K_CLEANUP, 3'd0, 1'b0, 32'd400, 1'b0);
    send_command(K_CLOSE, 3'd3, 1'b0, 32'd300, 1'b0);
    send_command(K_DISPATCH, 3'd0, 1'b0, 32'd500, 1'b0);
    send_command(K_DISPATCH, 3'd0, 1'b0, 32'd500, 1'b0);
    send_command(K_IDLECHK, 3'd0, 1'b0, 32'd600, 1'b0);
    send_command(K_CONNECT, 3'd0, 1'b0, 32'hFFFF_FF00, 1'b0);
    send_command(K_IDLECHK, 3'd0, 1'b0, 32'd9000, 1'b0);
    send_command(K_IDLECHK, 3'd0, 1'b0, 32'd9000, 1'b0);
    send_command(K_ENQUEUE, 3'd4, 1'b0, 32'hFFFF_FFF0, 1'b0);
    send_command(K_CLEANUP, 3'd0, 1'b0, 32'h0000_0010, 1'b0);
    send_command(K_CLEANUP, 3'd0, 1'b0, 32'h8000_0000, 1'b0);
    drain();

    // Random phases under different register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cfg_write(REG_EXPIRY, 32'd0); cfg_write(REG_IDLE, 32'hFFFF_FFFF); end
        1: begin cfg_write(REG_EXPIRY, 32'hFFFF_FFFF); cfg_write(REG_IDLE, 32'd0); end
        2: begin cfg_write(REG_EXPIRY, 32'd5000); cfg_write(REG_IDLE, 32'd5000); end
        default: begin
          cfg_write(REG_EXPIRY, 32'($urandom_range(0, 20000)));
          cfg_write(REG_IDLE, 32'($urandom_range(0, 20000)));
        end
      endcase
      for (int k = 0; k < 52; k++) random_command($urandom_range(0, 3) != 0);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
